@@ hdl/base64_stream_codec_defines.svh @@
// assertion helpers shared by the codec rtl
`ifndef BASE64_STREAM_CODEC_DEFINES_SVH
`define BASE64_STREAM_CODEC_DEFINES_SVH

// same-cycle implication, checked out of reset
`define B64SC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define B64SC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/b64sc_pkg.sv @@
package b64sc_pkg;

    typedef logic [7:0] b64_byte_t;

    localparam b64_byte_t CHAR_PAD_STD = 8'h3D;   // '='
    localparam b64_byte_t CHAR_PAD_URL = 8'h2E;   // '.'

    // register indexes on the config channel
    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_URL_ALPHA = 1'b1;

    localparam logic DIR_ENCODE = 1'b0;

    localparam logic [2:0] GROUP_BYTES = 3'd4;

    function automatic b64_byte_t sextet_char(input logic [5:0] v, input logic url);
        b64_byte_t c;
        if (v < 6'd26)
            c = 8'h41 + {2'b00, v};
        else if (v < 6'd52)
            c = 8'h61 + ({2'b00, v} - 8'd26);
        else if (v < 6'd62)
            c = 8'h30 + ({2'b00, v} - 8'd52);
        else if (v == 6'd62)
            c = url ? 8'h2D : 8'h2B;
        else
            c = url ? 8'h5F : 8'h2F;
        return c;
    endfunction

    // unknown characters map to zero, both alphabets accepted
    function automatic logic [5:0] char_sextet(input b64_byte_t c);
        b64_byte_t t;
        t = 8'd0;
        if (c >= 8'h41 && c <= 8'h5A)
            t = c - 8'h41;
        else if (c >= 8'h61 && c <= 8'h7A)
            t = c - 8'h61 + 8'd26;
        else if (c >= 8'h30 && c <= 8'h39)
            t = c - 8'h30 + 8'd52;
        else if (c == 8'h2B || c == 8'h2D)
            t = 8'd62;
        else if (c == 8'h2F || c == 8'h5F)
            t = 8'd63;
        return t[5:0];
    endfunction

endpackage

@@ hdl/base64_stream_codec.sv @@
// Base64 codec, one byte or character per input beat.
// s_* : input stream, s_tdata[7:0] = data_in, s_tlast = last_in (end of message).
// m_* : output stream, m_tdata[7:0] = data_out, m_tlast = run_last
//       (last output beat caused by one input beat).
// cfg_* : register writes, index 0 = direction (0 encode, 1 decode),
//         index 1 = url alphabet for encode ('-' '_' and '.' pad); write only
//         while no output is pending. cfg_ready is always high.
// Each input beat is decoded into a group register of up to four output
// bytes; the group drains one beat per cycle while the receiver is ready,
// first byte in the cycle after the input beat. The single output port sets
// the rate: s_tready is low while more than one beat of a group is pending,
// so a new input beat is taken only when the group is empty or down to its
// last byte. Beats that produce nothing pass at one per cycle once the group
// is down to its last byte.
// If the receiver stalls, the group holds and s_tready also stays low while
// the last byte is waiting. Reset clears the group state, the registers
// and any pending output.
`include "base64_stream_codec_defines.svh"

module base64_stream_codec
    import b64sc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] data_in
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [7:0] data_out
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic       cfg_data
);

    logic        dir_reg;
    logic        url_reg;
    logic [1:0]  pos_reg,  pos_next;
    logic [23:0] held_reg, held_next;
    logic [2:0]  pad_reg,  pad_next;
    b64_byte_t   grp_reg  [4];
    b64_byte_t   grp_next [4];
    logic [2:0]  rem_reg,  rem_next;

    logic        in_beat;
    logic        out_beat;
    logic [1:0]  enc_pos;
    logic [23:0] enc_held;
    logic [23:0] dec_held;
    logic [2:0]  filled;
    logic        emit;
    logic [2:0]  emit_cnt;
    b64_byte_t   emit_grp [4];
    b64_byte_t   pad_char;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = (rem_reg != 3'd0);
    assign m_tdata   = grp_reg[0];
    assign m_tlast   = (rem_reg == 3'd1);
    assign out_beat  = m_tvalid && m_tready;
    assign s_tready  = (rem_reg == 3'd0) || (rem_reg == 3'd1 && m_tready);
    assign in_beat   = s_tvalid && s_tready;
    assign pad_char  = url_reg ? CHAR_PAD_URL : CHAR_PAD_STD;

    always_comb
    begin
        enc_pos = (pos_reg == 2'd3) ? 2'd2 : pos_reg;
        case (enc_pos)
            2'd0:    enc_held = held_reg | {s_tdata, 16'h0000};
            2'd1:    enc_held = held_reg | {8'h00, s_tdata, 8'h00};
            default: enc_held = held_reg | {16'h0000, s_tdata};
        endcase
        case (pos_reg)
            2'd0:    dec_held = held_reg | {char_sextet(s_tdata), 18'd0};
            2'd1:    dec_held = held_reg | {6'd0, char_sextet(s_tdata), 12'd0};
            2'd2:    dec_held = held_reg | {12'd0, char_sextet(s_tdata), 6'd0};
            default: dec_held = held_reg | {18'd0, char_sextet(s_tdata)};
        endcase
        filled    = {1'b0, enc_pos} + 3'd1;
        pos_next  = pos_reg;
        held_next = held_reg;
        pad_next  = pad_reg;
        emit      = 1'b0;
        emit_cnt  = 3'd0;
        for (int i = 0; i < 4; i++)
            emit_grp[i] = 8'h00;

        if (dir_reg == DIR_ENCODE)
        begin
            if (filled == 3'd3 || s_tlast)
            begin
                emit     = 1'b1;
                emit_cnt = GROUP_BYTES;
                emit_grp[0] = sextet_char(enc_held[23:18], url_reg);
                emit_grp[1] = sextet_char(enc_held[17:12], url_reg);
                emit_grp[2] = (filled >= 3'd2) ? sextet_char(enc_held[11:6], url_reg)
                                               : pad_char;
                emit_grp[3] = (filled == 3'd3) ? sextet_char(enc_held[5:0], url_reg)
                                               : pad_char;
                pos_next  = 2'd0;
                held_next = 24'd0;
                pad_next  = 3'd0;
            end
            else
            begin
                pos_next  = filled[1:0];
                held_next = enc_held;
            end
        end
        else
        begin
            if (s_tdata == CHAR_PAD_STD)
            begin
                held_next = held_reg;
                if (pad_reg != 3'd7)
                    pad_next = pad_reg + 3'd1;
            end
            else
                held_next = dec_held;

            if (pos_reg == 2'd3)
            begin
                // pads remove bytes from the low end of the group
                emit        = 1'b1;
                emit_cnt    = (pad_next >= 3'd3) ? 3'd0 : 3'd3 - pad_next;
                emit_grp[0] = held_next[23:16];
                emit_grp[1] = held_next[15:8];
                emit_grp[2] = held_next[7:0];
                pos_next  = 2'd0;
                held_next = 24'd0;
                pad_next  = 3'd0;
            end
            else if (s_tlast)
            begin
                pos_next  = 2'd0;
                held_next = 24'd0;
                pad_next  = 3'd0;
            end
            else
                pos_next = pos_reg + 2'd1;
        end
    end

    always_comb
    begin
        rem_next = rem_reg;
        for (int i = 0; i < 4; i++)
            grp_next[i] = grp_reg[i];
        if (in_beat && emit)
        begin
            rem_next = emit_cnt;
            for (int i = 0; i < 4; i++)
                grp_next[i] = emit_grp[i];
        end
        else if (out_beat)
        begin
            rem_next = rem_reg - 3'd1;
            for (int i = 0; i < 3; i++)
                grp_next[i] = grp_reg[i + 1];
            grp_next[3] = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg  <= 1'b0;
            url_reg  <= 1'b0;
            pos_reg  <= 2'd0;
            held_reg <= 24'd0;
            pad_reg  <= 3'd0;
            rem_reg  <= 3'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DIRECTION: dir_reg <= cfg_data;
                    REG_URL_ALPHA: url_reg <= cfg_data;
                    default:       dir_reg <= dir_reg;
                endcase
            end
            if (in_beat)
            begin
                pos_reg  <= pos_next;
                held_reg <= held_next;
                pad_reg  <= pad_next;
            end
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
            grp_reg[i] <= grp_next[i];
    end

    `B64SC_ASSERT_NOW(a_no_take_while_busy, rem_reg > 3'd1, !s_tready,
        "input taken while more than one output beat pending")
    `B64SC_ASSERT_NOW(a_rem_range, 1'b1, rem_reg <= GROUP_BYTES,
        "output group count out of range")
    `B64SC_ASSERT_NEXT(a_enc_flush, s_tvalid && s_tready && dir_reg == DIR_ENCODE && s_tlast,
        rem_reg == GROUP_BYTES && pos_reg == 2'd0,
        "encode message end did not load a full group")
    `B64SC_ASSERT_NEXT(a_dec_group, s_tvalid && s_tready && dir_reg != DIR_ENCODE
        && pos_reg == 2'd3, pos_reg == 2'd0 && pad_reg == 3'd0 && rem_reg <= 3'd3,
        "decode group not closed after fourth character")

endmodule

@@ dv/tb_base64_stream_codec.sv @@
module tb_base64_stream_codec
    import b64sc_pkg::*;
;

    localparam logic DIR_DECODE = ~DIR_ENCODE;
    localparam int   PHASE_ITEMS = 20;

    typedef struct packed {
        b64_byte_t data;
        logic      last;
    } coded_beat_t;

    // running model of the codec plus the beats it still owes
    class base64_tracker;
        logic        direction;
        logic        url;
        logic [1:0]  group_pos;
        logic [23:0] held_bits;
        logic [2:0]  pad_count;
        coded_beat_t coded_q[$];
        int          errors;

        function new();
            direction = DIR_ENCODE;
            url       = 1'b0;
            errors    = 0;
            clear_group();
        endfunction

        function void clear_group();
            group_pos = 2'd0;
            held_bits = 24'd0;
            pad_count = 3'd0;
        endfunction

        function void set_reg(input logic idx, input logic val);
            if (idx == REG_DIRECTION)
                direction = val;
            else
                url = val;
        endfunction

        function void owe_beat(input b64_byte_t d, input logic l);
            coded_beat_t b;
            b.data = d;
            b.last = l;
            coded_q.insert(coded_q.size(), b);
        endfunction

        function b64_byte_t sextet_to_ascii(input logic [5:0] v, input logic u);
            if (v < 6'd26)
                return "A" + 8'(v);
            else if (v < 6'd52)
                return "a" + 8'(v) - 8'd26;
            else if (v < 6'd62)
                return "0" + 8'(v) - 8'd52;
            else if (v == 6'd62)
                return u ? "-" : "+";
            return u ? "_" : "/";
        endfunction

        // both alphabets accepted, anything else is zero
        function logic [5:0] ascii_to_sextet(input b64_byte_t c);
            if (c >= "A" && c <= "Z")
                return 6'(c - "A");
            else if (c >= "a" && c <= "z")
                return 6'(c - "a" + 8'd26);
            else if (c >= "0" && c <= "9")
                return 6'(c - "0" + 8'd52);
            else if (c == "+" || c == "-")
                return 6'd62;
            else if (c == "/" || c == "_")
                return 6'd63;
            return 6'd0;
        endfunction

        function void take_beat(input b64_byte_t d, input logic l);
            logic [1:0] pos;
            logic [2:0] filled;
            b64_byte_t  ch;
            int         nbytes;
            pos = group_pos;
            if (direction == DIR_ENCODE)
            begin
                // a group left at three characters by decode is treated as two bytes
                if (pos == 2'd3)
                    pos = 2'd2;
                held_bits = held_bits | (24'(d) << (16 - 8 * pos));
                filled = 3'(pos) + 3'd1;
                if (filled == 3'd3 || l)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (i <= filled)
                            ch = sextet_to_ascii(6'(held_bits >> (18 - 6 * i)), url);
                        else
                            ch = url ? CHAR_PAD_URL : CHAR_PAD_STD;
                        owe_beat(ch, i == 3);
                    end
                    clear_group();
                end
                else
                    group_pos = filled[1:0];
                return;
            end
            if (d == CHAR_PAD_STD)
            begin
                if (pad_count != 3'd7)
                    pad_count++;
            end
            else
                held_bits = held_bits | (24'(ascii_to_sextet(d)) << (18 - 6 * pos));
            if (pos == 2'd3)
            begin
                nbytes = (pad_count >= 3'd3) ? 0 : 3 - int'(pad_count);
                for (int i = 0; i < nbytes; i++)
                    owe_beat(8'(held_bits >> (16 - 8 * i)), i == nbytes - 1);
                clear_group();
            end
            else if (l)
                clear_group();
            else
                group_pos = pos + 2'd1;
        endfunction

        function void match_beat(input b64_byte_t d, input logic l);
            coded_beat_t want;
            if (coded_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, got data %h last %b", $time, d, l);
                return;
            end
            want = coded_q.pop_front();
            if (want.data !== d)
            begin
                errors++;
                $display("%0t: data expected %h, got %h", $time, want.data, d);
            end
            if (want.last !== l)
            begin
                errors++;
                $display("%0t: last expected %b, got %b", $time, want.last, l);
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      s_tvalid;
    logic      s_tready;
    b64_byte_t s_tdata;
    logic      s_tlast;
    logic      m_tvalid;
    logic      m_tready;
    b64_byte_t m_tdata;
    logic      m_tlast;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_index;
    logic      cfg_data;

    base64_tracker book;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            hold_span;
    int            items_sent;

    base64_stream_codec i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            book.match_beat(m_tdata, m_tlast);
    end

    // receiver: random stalls plus one long hold-off on request
    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_span != 0 && !hold_taken)
            begin
                hold_left  = hold_span;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    task automatic send_item(input b64_byte_t d, input logic l);
        bit paused;
        paused = 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            if (!paused)
                s_tvalid <= 1'b0;
            paused = 1'b1;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        do
            @(posedge clk);
        while (!s_tready);
        book.take_beat(d, l);
        items_sent++;
    endtask

    // all owed beats seen, then a few cycles for beats that give nothing
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (book.coded_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_mode(input logic dir, input logic u);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_DIRECTION;
        cfg_data  <= dir;
        do
            @(posedge clk);
        while (!cfg_ready);
        book.set_reg(REG_DIRECTION, dir);
        cfg_index <= REG_URL_ALPHA;
        cfg_data  <= u;
        do
            @(posedge clk);
        while (!cfg_ready);
        book.set_reg(REG_URL_ALPHA, u);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_byte_message();
        int len;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 10);
        for (int k = 0; k < len; k++)
            send_item(8'($urandom_range(0, 255)), k == len - 1);
    endtask

    // mostly well-formed text, some noise with stray pads and junk
    task automatic send_text_message();
        int        groups;
        int        npad;
        int        len;
        b64_byte_t ch;
        if ($urandom_range(0, 4) != 0)
        begin
            groups = $urandom_range(1, 3);
            npad   = $urandom_range(0, 2);
            for (int g = 0; g < groups; g++)
                for (int k = 0; k < 4; k++)
                begin
                    ch = book.sextet_to_ascii(6'($urandom_range(0, 63)),
                                              1'($urandom_range(0, 1)));
                    if (g == groups - 1 && k >= 4 - npad)
                        ch = CHAR_PAD_STD;
                    send_item(ch, g == groups - 1 && k == 3);
                end
        end
        else
        begin
            len = $urandom_range(1, 9);
            for (int k = 0; k < len; k++)
            begin
                case ($urandom_range(0, 3))
                    0:       ch = CHAR_PAD_STD;
                    1:       ch = 8'($urandom_range(0, 255));
                    default: ch = book.sextet_to_ascii(6'($urandom_range(0, 63)),
                                                       1'($urandom_range(0, 1)));
                endcase
                send_item(ch, k == len - 1);
            end
        end
    endtask

    initial
    begin
        int   start;
        int   m;
        logic dir;
        s_tvalid       = 1'b0;
        s_tdata        = 8'd0;
        s_tlast        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_DIRECTION;
        cfg_data       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_span      = 0;
        items_sent     = 0;
        book           = new();
        rst_n          = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_mode(DIR_ENCODE, 1'b0);
        // all-62 group, one-byte flush, two-byte flush
        send_item(8'hFB, 1'b0);
        send_item(8'hEF, 1'b0);
        send_item(8'hBE, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b1);
        set_mode(DIR_ENCODE, 1'b1);
        send_item(8'hFB, 1'b0);
        send_item(8'hEF, 1'b0);
        send_item(8'hBE, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        // byte left in the group across a switch to decode
        send_item(8'h41, 1'b0);
        set_mode(DIR_DECODE, 1'b1);
        send_item("Q", 1'b0);
        send_item(CHAR_PAD_STD, 1'b0);
        send_item(CHAR_PAD_STD, 1'b0);
        // an all-pad group gives nothing
        repeat (4) send_item(CHAR_PAD_STD, 1'b0);
        // unknown characters count as zero, url-safe characters accepted
        send_item(".", 1'b0);
        send_item("-", 1'b0);
        send_item(8'hFF, 1'b0);
        send_item("_", 1'b1);
        // three characters left in the group across a switch to encode
        send_item("Z", 1'b0);
        send_item("z", 1'b0);
        send_item("9", 1'b0);
        set_mode(DIR_ENCODE, 1'b0);
        send_item(8'h80, 1'b1);

        for (int p = 0; p < 9; p++)
        begin
            dir = p[0] ? DIR_DECODE : DIR_ENCODE;
            m   = (p / 2) % 4;
            set_mode(dir, p[2]);
            send_idle_pct  = (m == 1) ? 86 : (m == 3) ? 20 : 0;
            recv_stall_pct = (m == 2) ? 86 : (m == 3) ? 20 : 0;
            // receiver backs off for a long stretch while bytes keep coming
            if (p == 0)
                hold_span <= 300;
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                if (dir == DIR_ENCODE)
                    send_byte_message();
                else
                    send_text_message();
            end
        end

        recv_stall_pct = 0;
        wait_idle();
        if (book.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
